>>> rtl/sbcs_pkg.sv
// shared types, constants and control structs of the similar base chunk selector
package sbcs_pkg;

  localparam int FEATURES_PER_CHUNK_DEF = 4;
  localparam int TABLE_ENTRIES_DEF      = 1024;
  localparam int IDENT_BITS_DEF         = 64;

  localparam int KEY_W   = 64;
  localparam int BASE_W  = 64;
  localparam int COUNT_W = 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  // slot reduction for a table size that is not a power of two
  localparam int SLOT_BITS_PER_STEP = 4;
  localparam int SLOT_STEPS         = KEY_W / SLOT_BITS_PER_STEP;
  localparam int SLOT_CNT_W         = $clog2(SLOT_STEPS);

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [KEY_W-1:0]  feature_key;
    logic [BASE_W-1:0] base_ident;
    logic              last_feature;
  } req_t;

  typedef struct packed {
    logic               similar;
    logic [BASE_W-1:0]  chosen_base;
    logic [COUNT_W-1:0] match_count;
  } res_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic mem_write;
    logic mem_read;
    logic check;
  } cmd_t;

  typedef struct packed {
    logic slot_done;
    logic clear_last;
    logic is_insert;
    logic is_last;
    logic out_blocked;
  } status_t;

endpackage

>>> rtl/sbcs_slot.sv
// slot index unit: folds the key and reduces it modulo the table size
module sbcs_slot #(
  parameter int TABLE_ENTRIES = sbcs_pkg::TABLE_ENTRIES_DEF,
  parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sbcs_pkg::KEY_W-1:0] key,
  output logic                       done,
  output logic [IDX_W-1:0]           slot
);
  import sbcs_pkg::*;

  localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

  logic [KEY_W-1:0] folded;

  assign folded = {key[KEY_W-1:KEY_W/2], key[KEY_W/2-1:0] ^ key[KEY_W-1:KEY_W/2]};

  generate
    if (IS_POW2) begin : g_mask
      logic             done_q;
      logic [IDX_W-1:0] slot_q;

      always_ff @(posedge clk) begin
        if (rst) begin
          done_q <= 1'b0;
        end else begin
          done_q <= start;
        end
        if (start) begin
          slot_q <= folded[IDX_W-1:0];
        end
      end

      assign done = done_q;
      assign slot = slot_q;
    end else begin : g_reduce
      logic                  busy;
      logic                  done_q;
      logic [SLOT_CNT_W-1:0] cnt;
      logic [KEY_W-1:0]      sh;
      logic [IDX_W-1:0]      rem;
      logic [IDX_W-1:0]      rem_next;
      logic [IDX_W:0]        trial;

      // restoring reduction, most significant bits first
      always_comb begin
        rem_next = rem;
        trial    = '0;
        for (int k = 0; k < SLOT_BITS_PER_STEP; k++) begin
          trial = {rem_next, sh[KEY_W-1-k]};
          if (trial >= (IDX_W+1)'(TABLE_ENTRIES)) begin
            trial = trial - (IDX_W+1)'(TABLE_ENTRIES);
          end
          rem_next = trial[IDX_W-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          busy   <= 1'b0;
          done_q <= 1'b0;
          cnt    <= '0;
        end else begin
          done_q <= 1'b0;
          if (start) begin
            busy <= 1'b1;
            cnt  <= '0;
          end else if (busy) begin
            cnt <= cnt + 1'b1;
            if (cnt == SLOT_CNT_W'(SLOT_STEPS - 1)) begin
              busy   <= 1'b0;
              done_q <= 1'b1;
            end
          end
        end
        if (start) begin
          sh  <= folded;
          rem <= '0;
        end else if (busy) begin
          sh  <= sh << SLOT_BITS_PER_STEP;
          rem <= rem_next;
        end
      end

      assign done = done_q;
      assign slot = rem;
    end
  endgenerate

endmodule

>>> rtl/sbcs_datapath.sv
// datapath: request register, feature table, candidate list and result register
module sbcs_datapath #(
  parameter int FEATURES_PER_CHUNK = sbcs_pkg::FEATURES_PER_CHUNK_DEF,
  parameter int TABLE_ENTRIES      = sbcs_pkg::TABLE_ENTRIES_DEF,
  parameter int IDENT_BITS         = sbcs_pkg::IDENT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  sbcs_pkg::req_t    request,
  input  logic              result_stall,
  output logic              result_valid,
  output sbcs_pkg::res_t    result,
  input  sbcs_pkg::cmd_t    cmd,
  output sbcs_pkg::status_t status
);
  import sbcs_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int IW    = (FEATURES_PER_CHUNK > 1) ? $clog2(FEATURES_PER_CHUNK) : 1;
  localparam int UW    = $clog2(FEATURES_PER_CHUNK + 1);
  localparam int MEM_W = 1 + KEY_W + IDENT_BITS;

  req_t             item;
  logic             slot_done;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] clr_idx;

  logic [MEM_W-1:0] mem [TABLE_ENTRIES];
  logic [MEM_W-1:0] rd_q;
  logic [MEM_W-1:0] wdata;
  logic [IDX_W-1:0] waddr;
  logic             we;

  logic [IDENT_BITS-1:0] cand_base  [FEATURES_PER_CHUNK];
  logic [COUNT_W-1:0]    cand_count [FEATURES_PER_CHUNK];
  logic [UW-1:0]         cand_used;
  logic [IW-1:0]         best_idx;
  logic [COUNT_W-1:0]    best_cnt;

  logic [IDENT_BITS-1:0] cand_base_next  [FEATURES_PER_CHUNK];
  logic [COUNT_W-1:0]    cand_count_next [FEATURES_PER_CHUNK];
  logic [UW-1:0]         cand_used_next;
  logic [IW-1:0]         best_idx_next;
  logic [COUNT_W-1:0]    best_cnt_next;

  logic                  rd_valid;
  logic [KEY_W-1:0]      rd_key;
  logic [IDENT_BITS-1:0] rd_value;
  logic                  hit;
  logic                  found;
  logic [IW-1:0]         found_idx;
  logic [COUNT_W-1:0]    new_cnt;
  logic [IW-1:0]         used_idx;

  res_t res_next;
  res_t out_q;
  logic out_valid;

  sbcs_slot #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_slot (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.capture),
    .key  (request.feature_key),
    .done (slot_done),
    .slot (slot)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= request;
    end
  end

  // clearing pass over the table after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  assign we    = cmd.clear | cmd.mem_write;
  assign waddr = cmd.clear ? clr_idx : slot;
  assign wdata = cmd.clear ? '0 : {1'b1, item.feature_key, item.base_ident[IDENT_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.mem_read) begin
      rd_q <= mem[slot];
    end
  end

  assign rd_valid = rd_q[MEM_W-1];
  assign rd_key   = rd_q[MEM_W-2 -: KEY_W];
  assign rd_value = rd_q[IDENT_BITS-1:0];
  assign hit      = rd_valid && (rd_key == item.feature_key);
  assign used_idx = cand_used[IW-1:0];

  // earliest listed candidate holding the hit base
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = FEATURES_PER_CHUNK - 1; i >= 0; i--) begin
      if ((UW'(i) < cand_used) && (cand_base[i] == rd_value)) begin
        found     = 1'b1;
        found_idx = IW'(i);
      end
    end
  end

  // best is kept as the earliest candidate with the highest count
  always_comb begin
    cand_base_next  = cand_base;
    cand_count_next = cand_count;
    cand_used_next  = cand_used;
    best_idx_next   = best_idx;
    best_cnt_next   = best_cnt;
    new_cnt         = cand_count[found_idx] + 1'b1;
    if (hit) begin
      if (found) begin
        if (cand_count[found_idx] != COUNT_MAX) begin
          cand_count_next[found_idx] = new_cnt;
          if ((new_cnt > best_cnt) || ((new_cnt == best_cnt) && (found_idx < best_idx))) begin
            best_idx_next = found_idx;
            best_cnt_next = new_cnt;
          end
        end
      end else if (cand_used < UW'(FEATURES_PER_CHUNK)) begin
        cand_base_next[used_idx]  = rd_value;
        cand_count_next[used_idx] = COUNT_W'(1);
        cand_used_next            = cand_used + 1'b1;
        if (cand_used == '0) begin
          best_idx_next = used_idx;
          best_cnt_next = COUNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    res_next = '0;
    if (cand_used_next != '0) begin
      res_next.similar     = 1'b1;
      res_next.chosen_base = BASE_W'(cand_base_next[best_idx_next]);
      res_next.match_count = cand_count_next[best_idx_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_used <= '0;
      best_idx  <= '0;
      best_cnt  <= '0;
      for (int i = 0; i < FEATURES_PER_CHUNK; i++) begin
        cand_count[i] <= '0;
      end
    end else if (cmd.check) begin
      if (item.last_feature) begin
        cand_used <= '0;
        best_idx  <= '0;
        best_cnt  <= '0;
        for (int i = 0; i < FEATURES_PER_CHUNK; i++) begin
          cand_count[i] <= '0;
        end
      end else begin
        cand_used  <= cand_used_next;
        best_idx   <= best_idx_next;
        best_cnt   <= best_cnt_next;
        cand_count <= cand_count_next;
      end
    end
    if (cmd.check) begin
      cand_base <= cand_base_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.check && item.last_feature) begin
      out_valid <= 1'b1;
    end else if (!result_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.check && item.last_feature) begin
      out_q <= res_next;
    end
  end

  assign result_valid = out_valid;
  assign result       = out_q;

  assign status.slot_done   = slot_done;
  assign status.clear_last  = (clr_idx == IDX_W'(TABLE_ENTRIES - 1));
  assign status.is_insert   = (item.req_type == REQ_INSERT);
  assign status.is_last     = item.last_feature;
  assign status.out_blocked = out_valid && result_stall;

endmodule

>>> rtl/sbcs_ctrl.sv
// controller: sequences the clearing pass, slot, table access and candidate update
module sbcs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  input  sbcs_pkg::status_t status,
  output sbcs_pkg::cmd_t    cmd
);
  import sbcs_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT,
    S_MEM,
    S_CHECK
  } state_t;

  state_t state;
  state_t state_next;
  logic   stall;

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state == S_IDLE) && request_valid;
    cmd.clear     = (state == S_CLEAR);
    cmd.mem_write = (state == S_MEM) && status.is_insert;
    cmd.mem_read  = (state == S_MEM) && !status.is_insert;
    // a closing lookup waits while the previous result is still held
    cmd.check     = (state == S_CHECK) && !(status.is_last && status.out_blocked);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (request_valid) begin
          state_next = S_SLOT;
        end
      end
      S_SLOT: begin
        if (status.slot_done) begin
          state_next = S_MEM;
        end
      end
      S_MEM: begin
        state_next = status.is_insert ? S_IDLE : S_CHECK;
      end
      S_CHECK: begin
        if (cmd.check) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      stall <= 1'b1;
    end else begin
      state <= state_next;
      stall <= (state_next != S_IDLE);
    end
  end

  assign request_stall = stall;

endmodule

>>> rtl/similar_base_chunk_select.sv
// similar base chunk selector: feature index and per-chunk base vote
//
// request channel: request_valid / request_stall / request. An insert writes
// base_ident under feature_key in a direct-mapped table, evicting whatever
// shared the slot. A lookup probes one feature of the current chunk; hits are
// tallied per base, and the lookup marked last_feature closes the chunk.
// result channel: result_valid / result_stall / result, one result per closed
// chunk: similar, the most frequent base (earliest seen on a tie) and its
// count, all zero when nothing matched.
// sequence with a power-of-two table: a lookup passes the slot, table and check
// states before the next acceptance, an insert the slot and table states only;
// the result register is loaded by the closing lookup's check. Other table
// sizes add a slot reduction to each request (four bits a cycle).
// reset: the table is swept one entry a cycle with request_stall high. A result
// waits in its register while result_stall is high; the next chunk's lookups
// go on, and only a closing lookup waits.
module similar_base_chunk_select #(
  parameter int FEATURES_PER_CHUNK = sbcs_pkg::FEATURES_PER_CHUNK_DEF,
  parameter int TABLE_ENTRIES      = sbcs_pkg::TABLE_ENTRIES_DEF,
  parameter int IDENT_BITS         = sbcs_pkg::IDENT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           request_valid,
  output logic           request_stall,
  input  sbcs_pkg::req_t request,
  output logic           result_valid,
  input  logic           result_stall,
  output sbcs_pkg::res_t result
);
  import sbcs_pkg::*;

  cmd_t    cmd;
  status_t status;

  sbcs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .status       (status),
    .cmd          (cmd)
  );

  sbcs_datapath #(
    .FEATURES_PER_CHUNK(FEATURES_PER_CHUNK),
    .TABLE_ENTRIES     (TABLE_ENTRIES),
    .IDENT_BITS        (IDENT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .result_stall(result_stall),
    .result_valid(result_valid),
    .result      (result),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

>>> rtl/sbcs_checker.sv
// port-level checks of the similar base chunk selector, bound to the top level
module sbcs_checker (
  input logic           clk,
  input logic           rst,
  input logic           request_valid,
  input logic           request_stall,
  input sbcs_pkg::req_t request,
  input logic           result_valid,
  input logic           result_stall,
  input sbcs_pkg::res_t result
);
  import sbcs_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_not_similar_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.similar |-> result.chosen_base == '0 && result.match_count == '0)
    else $error("result without a match carries a base or count");

  a_similar_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.similar |-> result.match_count != '0)
    else $error("similar result with zero count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    request_valid && !request_stall |=> request_stall)
    else $error("request taken while the previous one is in flight");

  a_reset_state: assert property (@(posedge clk)
    rst |=> request_stall && !result_valid)
    else $error("block not held off after reset");

endmodule

bind similar_base_chunk_select sbcs_checker u_sbcs_checker (
  .clk          (clk),
  .rst          (rst),
  .request_valid(request_valid),
  .request_stall(request_stall),
  .request      (request),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

>>> tb/similar_base_chunk_select_checker.sv
// checker: predicts each chunk verdict of the selector and compares the results
module similar_base_chunk_select_checker #(
  parameter int FEATURES_PER_CHUNK = sbcs_pkg::FEATURES_PER_CHUNK_DEF,
  parameter int TABLE_ENTRIES      = sbcs_pkg::TABLE_ENTRIES_DEF,
  parameter int IDENT_BITS         = sbcs_pkg::IDENT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           request_valid,
  input  logic           request_stall,
  input  sbcs_pkg::req_t request,
  input  logic           result_valid,
  input  logic           result_stall,
  input  sbcs_pkg::res_t result,
  output int             verdicts_due,
  output int             mismatch_total
);
  timeunit 1ns;
  timeprecision 1ps;
  import sbcs_pkg::*;

  localparam logic [BASE_W-1:0] IDENT_MASK = {BASE_W{1'b1}} >> (BASE_W - IDENT_BITS);

  logic [KEY_W-1:0]   tbl_key  [TABLE_ENTRIES];
  logic [BASE_W-1:0]  tbl_base [TABLE_ENTRIES];
  bit                 tbl_used [TABLE_ENTRIES];
  logic [BASE_W-1:0]  vote_base [FEATURES_PER_CHUNK];
  logic [COUNT_W-1:0] vote_hits [FEATURES_PER_CHUNK];
  int                 vote_len = 0;
  res_t               chunk_verdicts [$];
  int                 mismatches = 0;

  function automatic int slot_index(logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] folded;
    folded = key ^ (key >> 32);
    return int'(folded % 64'(TABLE_ENTRIES));
  endfunction

  task automatic tally_hit(logic [BASE_W-1:0] base);
    for (int i = 0; i < vote_len; i++) begin
      if (vote_base[i] == base) begin
        if (vote_hits[i] != COUNT_MAX) vote_hits[i]++;
        return;
      end
    end
    // list full: a new base is dropped
    if (vote_len < FEATURES_PER_CHUNK) begin
      vote_base[vote_len] = base;
      vote_hits[vote_len] = 1;
      vote_len++;
    end
  endtask

  task automatic apply_request(req_t r);
    int   s;
    int   best;
    res_t v;
    s = slot_index(r.feature_key);
    if (r.req_type == REQ_INSERT) begin
      tbl_key[s]  = r.feature_key;
      tbl_base[s] = r.base_ident & IDENT_MASK;
      tbl_used[s] = 1'b1;
      return;
    end
    if (tbl_used[s] && tbl_key[s] == r.feature_key) tally_hit(tbl_base[s]);
    if (!r.last_feature) return;
    v = '0;
    if (vote_len != 0) begin
      best = 0;
      // strict compare keeps the earliest seen base on a tie
      for (int i = 1; i < vote_len; i++) begin
        if (vote_hits[i] > vote_hits[best]) best = i;
      end
      v.similar     = 1'b1;
      v.chosen_base = vote_base[best] & IDENT_MASK;
      v.match_count = vote_hits[best];
    end
    chunk_verdicts.insert(chunk_verdicts.size(), v);
    vote_len = 0;
  endtask

  task automatic report_mismatch(string what, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected sim=%0b base=%h count=%0d, got sim=%0b base=%h count=%0d",
               $realtime, what, want.similar, want.chosen_base, want.match_count,
               got.similar, got.chosen_base, got.match_count);
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) tbl_used[i] = 1'b0;
      vote_len = 0;
      chunk_verdicts.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (chunk_verdicts.size() == 0) begin
          report_mismatch("result with no chunk closed", '0, result);
        end else begin
          want = chunk_verdicts.pop_front();
          if (want.similar !== result.similar ||
              want.chosen_base !== result.chosen_base ||
              want.match_count !== result.match_count) begin
            report_mismatch("wrong chunk verdict", want, result);
          end
        end
      end
      if (request_valid && !request_stall) apply_request(request);
    end
    verdicts_due   <= chunk_verdicts.size();
    mismatch_total <= mismatches;
  end

endmodule

>>> tb/similar_base_chunk_select_tb.sv
// top of the selector testbench: clock, reset, request stimulus and verdict
module similar_base_chunk_select_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbcs_pkg::*;

  localparam int BATCH = 1350;

  logic clk           = 1'b0;
  logic rst           = 1'b1;
  logic request_valid = 1'b0;
  logic result_stall  = 1'b0;
  req_t request       = '0;
  logic request_stall;
  logic result_valid;
  res_t result;

  int verdicts_due;
  int mismatch_total;
  int send_pct = 0;
  int recv_pct = 0;
  int sent     = 0;

  logic [KEY_W-1:0]  known_keys [$];
  logic [BASE_W-1:0] base_pool  [8];

  always #4 clk = ~clk;

  similar_base_chunk_select uut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  similar_base_chunk_select_checker chk (
    .clk            (clk),
    .rst            (rst),
    .request_valid  (request_valid),
    .request_stall  (request_stall),
    .request        (request),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .verdicts_due   (verdicts_due),
    .mismatch_total (mismatch_total)
  );

  always @(posedge clk) result_stall <= ($urandom_range(0, 99) < recv_pct);

  initial begin
    #4_000_000;
    $display("[similar_base_chunk_select] ERROR");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] pick_known();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  // same low half of the fold, so the same slot in a power-of-two table, but a different key
  function automatic logic [KEY_W-1:0] twin(logic [KEY_W-1:0] key);
    logic [31:0] m;
    m = $urandom | 32'd1;
    return key ^ {m, m};
  endfunction

  task automatic remember(logic [KEY_W-1:0] key);
    known_keys.insert(known_keys.size(), key);
    if (known_keys.size() > 48) void'(known_keys.pop_front());
  endtask

  task automatic send(logic kind, logic [KEY_W-1:0] key, logic [BASE_W-1:0] ident,
                      logic last);
    req_t r;
    r.req_type     = kind;
    r.feature_key  = key;
    r.base_ident   = ident;
    r.last_feature = last;
    while ($urandom_range(0, 99) < send_pct) begin
      request_valid <= 1'b0;
      @(posedge clk);
    end
    request_valid <= 1'b1;
    request       <= r;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
  endtask

  task automatic set_idling(int s, int r);
    send_pct = s;
    recv_pct <= r;
  endtask

  task automatic random_insert();
    int                roll;
    logic [KEY_W-1:0]  key;
    logic [BASE_W-1:0] base;
    roll = $urandom_range(0, 99);
    if (roll < 55) key = rand64();
    else if (roll < 80) key = twin(pick_known());
    else key = pick_known();
    base = ($urandom_range(0, 99) < 80) ? base_pool[$urandom_range(0, 7)] : rand64();
    send(REQ_INSERT, key, base, $urandom_range(0, 1));
    remember(key);
  endtask

  task automatic random_chunk();
    int               len;
    int               roll;
    bit               long_run;
    logic [KEY_W-1:0] hot;
    logic [KEY_W-1:0] key;
    long_run = ($urandom_range(0, 99) < 8);
    len      = long_run ? $urandom_range(16, 24) : $urandom_range(1, 6);
    hot      = pick_known();
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      // long runs lean on one key so its count saturates
      if (long_run && roll < 80) key = hot;
      else if (roll < 70) key = pick_known();
      else if (roll < 82) key = twin(pick_known());
      else key = rand64();
      if ($urandom_range(0, 99) < 6) random_insert();
      send(REQ_LOOKUP, key, rand64(), (i == len - 1) && ($urandom_range(0, 99) >= 3));
    end
  endtask

  initial begin : stimulus
    int phase;
    phase        = 0;
    base_pool[0] = '0;
    base_pool[1] = '1;
    for (int i = 2; i < 8; i++) base_pool[i] = rand64();
    set_idling(31, 78);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty table, then key extremes and an eviction by a slot twin of key zero
    send(REQ_LOOKUP, '0, '1, 1'b1);
    send(REQ_INSERT, '0, '1, 1'b0);
    send(REQ_INSERT, '1, '0, 1'b1);
    send(REQ_INSERT, 64'h0000_0001_0000_0001, base_pool[7], 1'b0);
    send(REQ_LOOKUP, '0, rand64(), 1'b0);
    send(REQ_LOOKUP, 64'h0000_0001_0000_0001, rand64(), 1'b0);
    send(REQ_LOOKUP, '1, rand64(), 1'b1);
    remember('1);
    remember(64'h0000_0001_0000_0001);

    // keys 2 and 3 share a base; five bases overflow the candidate list
    for (int i = 0; i < 6; i++) begin
      send(REQ_INSERT, 64'(i + 2), base_pool[(i < 2) ? 2 : i + 1], 1'b0);
      remember(64'(i + 2));
    end
    for (int i = 0; i < 7; i++) begin
      send(REQ_LOOKUP, (i < 4) ? 64'(i + 4) : (i == 6) ? 64'd4 : 64'(i - 2), rand64(),
           i == 6);
    end

    // insert inside an open chunk, tie goes to the earlier base
    send(REQ_LOOKUP, 64'd2, rand64(), 1'b0);
    send(REQ_INSERT, 64'd8, base_pool[4], 1'b0);
    send(REQ_LOOKUP, 64'd8, rand64(), 1'b1);
    remember(64'd8);

    while (sent < BATCH) begin
      if ($urandom_range(0, 99) < 25) random_insert();
      else random_chunk();
      if (phase == 0 && sent >= BATCH / 3) begin
        request_valid <= 1'b0;
        drain();
        set_idling(78, 31);
        phase = 1;
      end else if (phase == 1 && sent >= 2 * BATCH / 3) begin
        request_valid <= 1'b0;
        drain();
        set_idling(0, 0);
        phase = 2;
      end
    end

    request_valid <= 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (mismatch_total == 0 && verdicts_due == 0) begin
      $display("[similar_base_chunk_select] OK");
    end else begin
      $display("[similar_base_chunk_select] ERROR");
    end
    $finish;
  end

endmodule
